>>> sv/pgwalk_pkg.sv
package pgwalk_pkg;

	localparam int STORE_WORDS = 4096;
	localparam int TABLE_WORDS = 512;
	localparam int STORE_AW    = $clog2(STORE_WORDS);
	localparam int STORE_PAGES = STORE_WORDS / TABLE_WORDS;

	localparam logic CMD_WRITE     = 1'b0;
	localparam logic CMD_TRANSLATE = 1'b1;

	// index slice of the virtual address for the next table read
	localparam logic [1:0] IX_PDPT = 2'd0;
	localparam logic [1:0] IX_PD   = 2'd1;
	localparam logic [1:0] IX_PT   = 2'd2;

	// page size of a finished walk
	localparam logic [1:0] PG_1G = 2'd0;
	localparam logic [1:0] PG_2M = 2'd1;
	localparam logic [1:0] PG_4K = 2'd2;

	localparam int PTE_PRESENT_BIT = 0;
	localparam int PTE_LARGE_BIT   = 7;

	// configuration register index, taken from paddr[3]
	localparam logic REG_ROOT = 1'b0;

	typedef struct packed {
		logic        cmd;
		logic [11:0] word_index;
		logic [63:0] entry_value;
		logic [47:0] virtual_address;
	} req_t;

	typedef struct packed {
		logic        translated;
		logic [51:0] physical_address;
	} res_t;

	typedef struct packed {
		logic       wr;
		logic       load;
		logic       rd_root;
		logic       rd_next;
		logic [1:0] ix_sel;
		logic       fin;
		logic       ok;
		logic [1:0] pg_sel;
	} ctl_t;

	typedef struct packed {
		logic root_ok;
		logic present;
		logic big_page;
		logic next_ok;
	} sts_t;

endpackage

>>> sv/pgwalk_ctrl.sv
module pgwalk_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              cmd,
	input  pgwalk_pkg::sts_t  sts,
	output logic              busy,
	output pgwalk_pkg::ctl_t  ctl
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PML4 = 3'd1;
	localparam logic [2:0] ST_PDPT = 3'd2;
	localparam logic [2:0] ST_PD   = 3'd3;
	localparam logic [2:0] ST_PT   = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       accept;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	always_comb begin
		state_d     = state_q;
		ctl         = '0;
		ctl.ix_sel  = pgwalk_pkg::IX_PDPT;
		ctl.pg_sel  = pgwalk_pkg::PG_4K;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && cmd == pgwalk_pkg::CMD_WRITE) begin
					ctl.wr = 1'b1;
				end else if (accept) begin
					ctl.load = 1'b1;
					if (sts.root_ok) begin
						ctl.rd_root = 1'b1;
						state_d     = ST_PML4;
					end else begin
						ctl.fin = 1'b1;
					end
				end
			end
			ST_PML4: begin
				if (sts.present && sts.next_ok) begin
					ctl.rd_next = 1'b1;
					ctl.ix_sel  = pgwalk_pkg::IX_PDPT;
					state_d     = ST_PDPT;
				end else begin
					ctl.fin = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_PDPT: begin
				if (sts.present && sts.big_page) begin
					ctl.fin    = 1'b1;
					ctl.ok     = 1'b1;
					ctl.pg_sel = pgwalk_pkg::PG_1G;
					state_d    = ST_IDLE;
				end else if (sts.present && sts.next_ok) begin
					ctl.rd_next = 1'b1;
					ctl.ix_sel  = pgwalk_pkg::IX_PD;
					state_d     = ST_PD;
				end else begin
					ctl.fin = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_PD: begin
				if (sts.present && sts.big_page) begin
					ctl.fin    = 1'b1;
					ctl.ok     = 1'b1;
					ctl.pg_sel = pgwalk_pkg::PG_2M;
					state_d    = ST_IDLE;
				end else if (sts.present && sts.next_ok) begin
					ctl.rd_next = 1'b1;
					ctl.ix_sel  = pgwalk_pkg::IX_PT;
					state_d     = ST_PT;
				end else begin
					ctl.fin = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_PT: begin
				ctl.fin    = 1'b1;
				ctl.ok     = sts.present;
				ctl.pg_sel = pgwalk_pkg::PG_4K;
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> sv/pgwalk_dp.sv
module pgwalk_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pgwalk_pkg::ctl_t      ctl,
	input  pgwalk_pkg::req_t      req,
	input  logic [51:0]           root,
	output pgwalk_pkg::sts_t      sts,
	output pgwalk_pkg::res_t      rsp,
	output logic                  done
);

	logic [63:0]                     mem [pgwalk_pkg::STORE_WORDS];
	logic [63:0]                     rdata_q;
	logic [47:0]                     va_q;
	logic                            done_q;
	pgwalk_pkg::res_t                rsp_q;
	logic [39:0]                     root_page;
	logic [39:0]                     ent_page;
	logic [39:0]                     rd_page;
	logic [8:0]                      rd_idx;
	logic [pgwalk_pkg::STORE_AW-1:0] rd_addr;
	logic [pgwalk_pkg::STORE_AW-1:0] wr_addr;
	logic                            wr_en;
	logic [51:0]                     pa;

	assign root_page = root[51:12];
	assign ent_page  = rdata_q[51:12];

	assign sts.root_ok  = (root_page != '0) && (root_page < 40'(pgwalk_pkg::STORE_PAGES));
	assign sts.next_ok  = (ent_page < 40'(pgwalk_pkg::STORE_PAGES));
	assign sts.present  = rdata_q[pgwalk_pkg::PTE_PRESENT_BIT];
	assign sts.big_page = rdata_q[pgwalk_pkg::PTE_LARGE_BIT];

	always_comb begin
		rd_page = ctl.rd_root ? root_page : ent_page;
		if (ctl.rd_root) begin
			rd_idx = req.virtual_address[47:39];
		end else begin
			case (ctl.ix_sel)
				pgwalk_pkg::IX_PDPT: rd_idx = va_q[38:30];
				pgwalk_pkg::IX_PD:   rd_idx = va_q[29:21];
				pgwalk_pkg::IX_PT:   rd_idx = va_q[20:12];
				default:             rd_idx = '0;
			endcase
		end
	end

	// keep the low page bits above the nine index bits
	assign rd_addr = pgwalk_pkg::STORE_AW'({rd_page, rd_idx});
	assign wr_addr = pgwalk_pkg::STORE_AW'(req.word_index);
	assign wr_en   = ctl.wr && (32'(req.word_index) < pgwalk_pkg::STORE_WORDS);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= req.entry_value;
		end
		if (ctl.rd_root || ctl.rd_next) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			va_q <= req.virtual_address;
		end
	end

	always_comb begin
		case (ctl.pg_sel)
			pgwalk_pkg::PG_1G: pa = {rdata_q[51:30], va_q[29:0]};
			pgwalk_pkg::PG_2M: pa = {rdata_q[51:21], va_q[20:0]};
			default:           pa = {rdata_q[51:12], va_q[11:0]};
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.fin) begin
			rsp_q.translated       <= ctl.ok;
			rsp_q.physical_address <= ctl.ok ? pa : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl.fin;
		end
	end

	assign rsp  = rsp_q;
	assign done = done_q;

endmodule

>>> sv/four_level_page_table_walker.sv
// Four-level page table walker.
// Commands enter on req when start is high and busy is low. A write command
// stores req.entry_value at word req.word_index of the local table store in
// that same beat and gives no result; busy stays low. A translate command
// walks PML4, PDPT, PD and PT from the root base register and gives one
// result on rsp, marked by done for exactly one cycle.
// For a zero or out-of-store root, done follows in the cycle after accept.
// Else the walk makes one table read per level, PML4, PDPT, PD and PT for a
// 4 KiB page, down to PD for 2 MiB and to PDPT for 1 GiB, then loads the
// result register; these are dependent reads chained on the single read port
// of the table store, each with registered read data. A walk that fails at a
// level ends there. Busy is high while a translate walks, so no new command
// enters before its result; busy falls in the cycle its result shows, so a
// new command may enter then. The user writes the root base through the APB
// port at address 0 only while idle; the block itself does not enforce this.
// Reset clears the root base and the walk state; the store holds whatever
// it held, and walks must only read words written since reset.
// The receiver cannot stall: done marks a result in its done cycle only.
module four_level_page_table_walker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  pgwalk_pkg::req_t  req,
	output logic              done,
	output pgwalk_pkg::res_t  rsp,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [63:0]       pwdata,
	output logic [63:0]       prdata,
	output logic              pready
);

	logic [51:0]      root_q;
	pgwalk_pkg::ctl_t ctl;
	pgwalk_pkg::sts_t sts;

	assign pready = 1'b1;
	assign prdata = (paddr[3] == pgwalk_pkg::REG_ROOT) ? {12'b0, root_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_q <= '0;
		end else if (psel && penable && pwrite && pready && paddr[3] == pgwalk_pkg::REG_ROOT) begin
			root_q <= pwdata[51:0];
		end
	end

	pgwalk_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (req.cmd),
		.sts    (sts),
		.busy   (busy),
		.ctl    (ctl)
	);

	pgwalk_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.req    (req),
		.root   (root_q),
		.sts    (sts),
		.rsp    (rsp),
		.done   (done)
	);

	// a walk begins only on an accepted translate beat
	a_walk_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start && req.cmd == pgwalk_pkg::CMD_TRANSLATE))
		else $error("walk started without a translate beat");

	// leaving a walk always delivers its result
	a_walk_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("walk ended without a result");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while a walk is running");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !rsp.translated) |-> (rsp.physical_address == '0))
		else $error("failed walk with nonzero address");

	// a write beat never causes a result
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req.cmd == pgwalk_pkg::CMD_WRITE) |=> !done)
		else $error("result after a write beat");

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import pgwalk_pkg::*;

	localparam int LVL_PML4 = 0;
	localparam int LVL_PDPT = 1;
	localparam int LVL_PD   = 2;
	localparam int LVL_PT   = 3;

	localparam int MAX_GAP      = 16;
	localparam int DRAIN_CYCLES = 8;
	localparam int PHASES       = 6;
	localparam int TIMEOUT_NS   = 5_000_000;

	class walk_scoreboard;
		logic [63:0] table_mirror [STORE_WORDS];
		bit          written [STORE_WORDS];
		logic [51:0] root_base;
		res_t        pending_results[$];
		int          errors;

		function void set_root(input logic [63:0] value);
			root_base = value[51:0];
		endfunction

		// Walk the mirrored tables. hole names the first unwritten word the walk
		// would read (or -1), hole_lvl the level it sits at.
		function void walk_tables(input logic [47:0] va, output logic ok,
				output logic [51:0] pa, output int hole, output int hole_lvl);
			logic [51:0] tbl;
			logic [63:0] ent;
			logic [8:0]  ix;
			int          word;
			ok = 1'b0;
			pa = '0;
			hole = -1;
			hole_lvl = LVL_PML4;
			tbl = {root_base[51:12], 12'h000};
			if (tbl == '0)
				return;
			for (int lvl = LVL_PML4; lvl <= LVL_PT; lvl++) begin
				ix = va[47 - 9 * lvl -: 9];
				if (tbl[51:12] >= STORE_PAGES)
					return;
				word = int'(tbl[51:12]) * TABLE_WORDS + int'(ix);
				if (!written[word]) begin
					hole = word;
					hole_lvl = lvl;
					return;
				end
				ent = table_mirror[word];
				if (!ent[PTE_PRESENT_BIT])
					return;
				if (lvl == LVL_PDPT && ent[PTE_LARGE_BIT]) begin
					ok = 1'b1;
					pa = {ent[51:30], va[29:0]};
					return;
				end
				if (lvl == LVL_PD && ent[PTE_LARGE_BIT]) begin
					ok = 1'b1;
					pa = {ent[51:21], va[20:0]};
					return;
				end
				if (lvl == LVL_PT) begin
					ok = 1'b1;
					pa = {ent[51:12], va[11:0]};
					return;
				end
				tbl = {ent[51:12], 12'h000};
			end
		endfunction

		function void note_req(input req_t item);
			logic        ok;
			logic [51:0] pa;
			int          hole;
			int          hole_lvl;
			res_t        want;
			if (item.cmd == CMD_WRITE) begin
				table_mirror[item.word_index] = item.entry_value;
				written[item.word_index] = 1'b1;
				return;
			end
			walk_tables(item.virtual_address, ok, pa, hole, hole_lvl);
			want.translated = ok;
			want.physical_address = ok ? pa : '0;
			pending_results.push_back(want);
		endfunction

		function void check_rsp(input res_t got);
			res_t want;
			if (pending_results.size() == 0) begin
				$error("result with no translation pending: translated=%0d physical_address=%h",
					got.translated, got.physical_address);
				errors++;
				return;
			end
			want = pending_results.pop_front();
			if (got.translated !== want.translated) begin
				$error("translated: expected %0d, got %0d", want.translated, got.translated);
				errors++;
			end
			if (got.physical_address !== want.physical_address) begin
				$error("physical_address: expected %h, got %h",
					want.physical_address, got.physical_address);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	req_t        req;
	logic        done;
	res_t        rsp;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;

	walk_scoreboard board;
	int          idle_pct;
	int          items_sent;
	logic [47:0] va_pool[$];

	four_level_page_table_walker i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.req     (req),
		.done    (done),
		.rsp     (rsp),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			board.check_rsp(rsp);
	end

	task automatic send_item(input req_t item);
		int gap;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(0, 99) < idle_pct)
			gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req   <= item;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		board.note_req(item);
		items_sent++;
	endtask

	task automatic put_word(input int idx, input logic [63:0] value);
		req_t item;
		item.cmd = CMD_WRITE;
		item.word_index = 12'(idx);
		item.entry_value = value;
		item.virtual_address = {16'($urandom), $urandom};
		send_item(item);
	endtask

	task automatic ask(input logic [47:0] va);
		req_t item;
		item.cmd = CMD_TRANSLATE;
		item.word_index = 12'($urandom);
		item.entry_value = {$urandom, $urandom};
		item.virtual_address = va;
		send_item(item);
	endtask

	// Drop start, wait out every pending translation, then let the walker go quiet.
	task automatic drain_walks();
		start <= 1'b0;
		while (board.pending_results.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_root(input logic [63:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {REG_ROOT, 3'b000};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		board.set_root(value);
	endtask

	function automatic logic [63:0] make_entry(input int lvl);
		logic [63:0] e;
		e = {$urandom, $urandom};
		e[PTE_PRESENT_BIT] = ($urandom_range(0, 99) < 88);
		e[PTE_LARGE_BIT] = ($urandom_range(0, 99) < 25);
		// keep most table pointers inside the store so walks go deeper
		if (lvl != LVL_PT && !(e[PTE_LARGE_BIT] && (lvl == LVL_PDPT || lvl == LVL_PD))
				&& $urandom_range(0, 99) < 88)
			e[51:15] = '0;
		return e;
	endfunction

	function automatic logic [63:0] phase_root(input int ph);
		case (ph)
			0: return (64'($urandom_range(1, 7)) << 12) | 64'($urandom_range(0, 4095));
			1: return 64'h7FFF;
			2: return {12'($urandom), 40'($urandom_range(1, 7)), 12'($urandom)};
			3: return {$urandom, $urandom} | (64'h1 << 40);
			4: return 64'($urandom_range(0, 4095));
			default: return 64'h1000;
		endcase
	endfunction

	task automatic random_step();
		logic [47:0] va;
		logic        ok;
		logic [51:0] pa;
		int          hole;
		int          hole_lvl;
		int          roll;
		roll = $urandom_range(0, 99);
		if (roll < 10) begin
			put_word($urandom_range(0, STORE_WORDS - 1), {$urandom, $urandom});
			return;
		end
		if (roll < 50 || va_pool.size() == 0) begin
			va = {16'($urandom), $urandom};
			va_pool.push_back(va);
			if (va_pool.size() > 16)
				void'(va_pool.pop_front());
		end else begin
			va = va_pool[$urandom_range(0, va_pool.size() - 1)];
			va[11:0] = 12'($urandom);
			if ($urandom_range(0, 2) == 0)
				va[20:12] = 9'($urandom);
		end
		// fill each table word the walk would reach unwritten, top level first
		board.walk_tables(va, ok, pa, hole, hole_lvl);
		while (hole >= 0) begin
			put_word(hole, make_entry(hole_lvl));
			board.walk_tables(va, ok, pa, hole, hole_lvl);
		end
		ask(va);
	endtask

	initial begin
		#(TIMEOUT_NS);
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		int phase_items [PHASES];
		int target;
		phase_items = '{360, 360, 360, 60, 60, 440};
		board = new;
		idle_pct = 0;
		items_sent = 0;
		arst_n  <= 1'b0;
		start   <= 1'b0;
		req     <= '0;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= '0;
		pwdata  <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero root straight out of reset
		ask(48'hFFFF_FFFF_FFFF);
		drain_walks();
		write_root(64'h1000);
		// PML4 at page 1, PDPT page 2, PD page 3, PT page 4; top-level large bit ignored
		put_word(512, 64'hFFF0_0000_0000_2081);
		put_word(1024, 64'h3001);
		put_word(1536, 64'h4001);
		// largest frame, last-level large bit ignored
		put_word(2048, 64'h000F_FFFF_FFFF_F081);
		ask(48'h0000_0000_0FFF);
		// 1 GiB page with every entry bit set
		put_word(1025, '1);
		ask({9'd0, 9'd1, 30'h3FFF_FFFF});
		// 2 MiB page through PD at page 5
		put_word(1026, 64'h5001);
		put_word(2560, 64'h8000_0000_0020_0FFF);
		ask({9'd0, 9'd2, 9'd0, 21'h1A_BCDE});
		// absent entries at the top, second and last levels
		put_word(513, 64'hFFFF_FFFF_FFFF_FFFE);
		ask({9'd1, 39'h0});
		put_word(1027, 64'h0);
		ask({9'd0, 9'd3, 30'h0});
		put_word(2049, 64'h2);
		ask({9'd0, 9'd0, 9'd0, 9'd1, 12'h000});
		// next table beyond the store
		put_word(1028, 64'h8001);
		ask({9'd0, 9'd4, 30'h0});
		put_word(514, 64'h000F_FFFF_FFFF_F001);
		ask({9'd2, 39'h0});
		// root beyond the store, then a root with low bits set
		drain_walks();
		write_root('1);
		ask(48'h0);
		drain_walks();
		write_root(64'h1FFF);
		ask(48'h0000_0000_0ABC);

		for (int ph = 0; ph < PHASES; ph++) begin
			drain_walks();
			write_root(phase_root(ph));
			idle_pct = (ph < 2) ? 28 : (ph < 4) ? 64 : 0;
			target = items_sent + phase_items[ph];
			while (items_sent < target)
				random_step();
		end

		drain_walks();
		if (board.errors == 0 && board.pending_results.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
